// ===== sv/tpi_pkg.sv =====
// Shared constants for the triangle / plane intersection core.
// No dependencies.
package tpi_pkg;

    // Default coordinate width (signed Q16.16 at 32 bits).
    localparam int COORD_WIDTH_DEF = 32;

    // A triangle has three edges: AB, BC, CA.
    localparam int NUM_EDGES = 3;

endpackage

// ===== sv/triangle_plane_intersection_core.sv =====
// Triangle / horizontal plane intersection core, fully pipelined.
// Depends on tpi_pkg (constants).
//
// Cuts one triangle (A, B, C) per clock with the plane z = slice_height and reports
// the distinct crossing points of edges AB, BC, CA in that order. A triangle is
// taken at any clock edge where start is high; busy is always low, so one
// triangle can be issued every cycle. Each triangle yields exactly one result,
// shown for a single cycle with done high once the triangle has passed all
// stages. The bulk of the pipe is the six restoring dividers (x and y per
// edge), which retire one quotient bit per pipeline stage; ahead of them sit
// an edge setup stage, a multiply stage and a numerator combine stage, and a
// duplicate removal / packing stage follows them. Results cannot be held off,
// so nothing in the pipe ever stalls. slice_height is written over the cfg
// channel (cfg_ready is always high) and must only change while no triangle
// is in flight.
module triangle_plane_intersection_core
    import tpi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic signed [COORD_WIDTH-1:0] cfg_data,
    // triangle input
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] az,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by_coord,
    input  logic signed [COORD_WIDTH-1:0] bz,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    input  logic signed [COORD_WIDTH-1:0] cz,
    // result
    output logic                          done,
    output logic        [1:0]             point_count,
    output logic signed [COORD_WIDTH-1:0] first_x,
    output logic signed [COORD_WIDTH-1:0] first_y,
    output logic signed [COORD_WIDTH-1:0] second_x,
    output logic signed [COORD_WIDTH-1:0] second_y,
    output logic signed [COORD_WIDTH-1:0] third_x,
    output logic signed [COORD_WIDTH-1:0] third_y
);

    localparam int W   = COORD_WIDTH;
    localparam int NE  = NUM_EDGES;
    localparam int LAT = W + 4;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // slice height register
    // ------------------------------------------------------------------
    logic signed [W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            height_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: edge classification, weights and coordinate magnitudes.
    // Flat edge on the plane becomes blend(x1, x2, 1, 0, 1) = x1.
    // ------------------------------------------------------------------
    logic signed [W-1:0] vx [NE];
    logic signed [W-1:0] vy [NE];
    logic signed [W-1:0] vz [NE];

    assign vx[0] = ax;  assign vy[0] = ay;        assign vz[0] = az;
    assign vx[1] = bx;  assign vy[1] = by_coord;  assign vz[1] = bz;
    assign vx[2] = cx;  assign vy[2] = cy;        assign vz[2] = cz;

    logic         a_hit_next [NE];
    logic [W-1:0] a_wa_next  [NE];
    logic [W-1:0] a_wb_next  [NE];
    logic [W-1:0] a_den_next [NE];
    logic [W-1:0] a_mag_next [NE][2][2];   // edge, axis, endpoint
    logic         a_sgn_next [NE][2][2];

    always_comb
    begin
        logic signed [W:0]   z1;
        logic signed [W:0]   z2;
        logic signed [W:0]   hh;
        logic signed [W:0]   wa;
        logic signed [W:0]   wb;
        logic signed [W:0]   dn;
        logic                down;
        logic                up;
        logic                flat;
        logic signed [W-1:0] crd;
        logic [W-1:0]        neg_crd;
        int                  nx;
        for (int eg = 0; eg < NE; eg++)
        begin
            nx   = (eg + 1) % NE;
            z1   = {vz[eg][W-1], vz[eg]};
            z2   = {vz[nx][W-1], vz[nx]};
            hh   = {height_reg[W-1], height_reg};
            down = (z1 >= hh) && (hh >= z2);
            up   = (z2 >= hh) && (hh >= z1);
            flat = (z1 == z2);
            if (down)
            begin
                wa = hh - z2;
                wb = z1 - hh;
                dn = z1 - z2;
            end
            else
            begin
                wa = z2 - hh;
                wb = hh - z1;
                dn = z2 - z1;
            end
            a_hit_next[eg] = down || up;
            if (flat || !(down || up))
            begin
                a_wa_next[eg]  = flat ? W'(1) : '0;
                a_wb_next[eg]  = '0;
                a_den_next[eg] = W'(1);
            end
            else
            begin
                a_wa_next[eg]  = wa[W-1:0];
                a_wb_next[eg]  = wb[W-1:0];
                a_den_next[eg] = dn[W-1:0];
            end
            for (int ax_i = 0; ax_i < 2; ax_i++)
            begin
                for (int ep = 0; ep < 2; ep++)
                begin
                    if (ax_i == 0)
                    begin
                        crd = (ep == 0) ? vx[eg] : vx[nx];
                    end
                    else
                    begin
                        crd = (ep == 0) ? vy[eg] : vy[nx];
                    end
                    neg_crd = W'(-crd);
                    a_sgn_next[eg][ax_i][ep] = crd[W-1];
                    a_mag_next[eg][ax_i][ep] = crd[W-1] ? neg_crd : W'(crd);
                end
            end
        end
    end

    logic         a_vld_reg;
    logic         a_hit_reg [NE];
    logic [W-1:0] a_wa_reg  [NE];
    logic [W-1:0] a_wb_reg  [NE];
    logic [W-1:0] a_den_reg [NE];
    logic [W-1:0] a_mag_reg [NE][2][2];
    logic         a_sgn_reg [NE][2][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_hit_reg <= a_hit_next;
        a_wa_reg  <= a_wa_next;
        a_wb_reg  <= a_wb_next;
        a_den_reg <= a_den_next;
        a_mag_reg <= a_mag_next;
        a_sgn_reg <= a_sgn_next;
    end

    // ------------------------------------------------------------------
    // Stage B: products |x1|*wa and |x2|*wb
    // ------------------------------------------------------------------
    logic           b_vld_reg;
    logic           b_hit_reg [NE];
    logic [W-1:0]   b_den_reg [NE];
    logic [2*W-1:0] b_prod_reg [NE][2][2];
    logic           b_sgn_reg [NE][2][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_hit_reg <= a_hit_reg;
        b_den_reg <= a_den_reg;
        b_sgn_reg <= a_sgn_reg;
        for (int eg = 0; eg < NE; eg++)
        begin
            for (int ax_i = 0; ax_i < 2; ax_i++)
            begin
                b_prod_reg[eg][ax_i][0] <= (2*W)'(a_mag_reg[eg][ax_i][0])
                                           * (2*W)'(a_wa_reg[eg]);
                b_prod_reg[eg][ax_i][1] <= (2*W)'(a_mag_reg[eg][ax_i][1])
                                           * (2*W)'(a_wb_reg[eg]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: signed-magnitude numerator, loaded into divider stage 0
    // ------------------------------------------------------------------
    logic [W-1:0] d_rem_reg [W+1][NE][2];
    logic [W-1:0] d_qn_reg  [W+1][NE][2];   // dividend low bits out, quotient in
    logic         d_neg_reg [W+1][NE][2];
    logic [W-1:0] d_den_reg [W+1][NE];
    logic         d_hit_reg [W+1][NE];
    logic         d_vld_reg [W+1];

    logic [2*W-1:0] c_num [NE][2];
    logic           c_neg [NE][2];

    always_comb
    begin
        logic [2*W-1:0] p1;
        logic [2*W-1:0] p2;
        logic           s1;
        logic           s2;
        for (int eg = 0; eg < NE; eg++)
        begin
            for (int ax_i = 0; ax_i < 2; ax_i++)
            begin
                p1 = b_prod_reg[eg][ax_i][0];
                p2 = b_prod_reg[eg][ax_i][1];
                s1 = b_sgn_reg[eg][ax_i][0];
                s2 = b_sgn_reg[eg][ax_i][1];
                if (s1 == s2)
                begin
                    c_num[eg][ax_i] = p1 + p2;
                    c_neg[eg][ax_i] = s1;
                end
                else if (p1 >= p2)
                begin
                    c_num[eg][ax_i] = p1 - p2;
                    c_neg[eg][ax_i] = s1;
                end
                else
                begin
                    c_num[eg][ax_i] = p2 - p1;
                    c_neg[eg][ax_i] = s2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg[0] <= 1'b0;
        end
        else
        begin
            d_vld_reg[0] <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_den_reg[0] <= b_den_reg;
        d_hit_reg[0] <= b_hit_reg;
        d_neg_reg[0] <= c_neg;
        for (int eg = 0; eg < NE; eg++)
        begin
            for (int ax_i = 0; ax_i < 2; ax_i++)
            begin
                d_rem_reg[0][eg][ax_i] <= c_num[eg][ax_i][2*W-1:W];
                d_qn_reg[0][eg][ax_i]  <= c_num[eg][ax_i][W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: one restoring quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= W; k++)
    begin : g_div
        logic [W-1:0] rem_next [NE][2];
        logic [W-1:0] qn_next  [NE][2];

        always_comb
        begin
            logic [W:0] trial;
            logic [W:0] diff;
            logic       qbit;
            for (int eg = 0; eg < NE; eg++)
            begin
                for (int ax_i = 0; ax_i < 2; ax_i++)
                begin
                    trial = {d_rem_reg[k-1][eg][ax_i], d_qn_reg[k-1][eg][ax_i][W-1]};
                    diff  = trial - {1'b0, d_den_reg[k-1][eg]};
                    qbit  = (trial >= {1'b0, d_den_reg[k-1][eg]});
                    rem_next[eg][ax_i] = qbit ? diff[W-1:0] : trial[W-1:0];
                    qn_next[eg][ax_i]  = {d_qn_reg[k-1][eg][ax_i][W-2:0], qbit};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_vld_reg[k] <= 1'b0;
            end
            else
            begin
                d_vld_reg[k] <= d_vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            d_rem_reg[k] <= rem_next;
            d_qn_reg[k]  <= qn_next;
            d_neg_reg[k] <= d_neg_reg[k-1];
            d_den_reg[k] <= d_den_reg[k-1];
            d_hit_reg[k] <= d_hit_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Final stage: apply sign, drop points repeated later, pack in order
    // ------------------------------------------------------------------
    logic [W-1:0] slot_x_next [NE];
    logic [W-1:0] slot_y_next [NE];
    logic [1:0]   count_next;

    always_comb
    begin
        logic [W-1:0] px   [NE];
        logic [W-1:0] py   [NE];
        logic         keep [NE];
        logic [1:0]   kept;
        for (int eg = 0; eg < NE; eg++)
        begin
            px[eg] = d_neg_reg[W][eg][0] ? W'(-d_qn_reg[W][eg][0]) : d_qn_reg[W][eg][0];
            py[eg] = d_neg_reg[W][eg][1] ? W'(-d_qn_reg[W][eg][1]) : d_qn_reg[W][eg][1];
        end
        for (int i = 0; i < NE; i++)
        begin
            keep[i] = d_hit_reg[W][i];
            for (int j = i + 1; j < NE; j++)
            begin
                if (d_hit_reg[W][j] && px[j] == px[i] && py[j] == py[i])
                begin
                    keep[i] = 1'b0;
                end
            end
        end
        for (int i = 0; i < NE; i++)
        begin
            slot_x_next[i] = '0;
            slot_y_next[i] = '0;
        end
        kept = '0;
        for (int i = 0; i < NE; i++)
        begin
            if (keep[i])
            begin
                slot_x_next[kept] = px[i];
                slot_y_next[kept] = py[i];
                kept = kept + 2'd1;
            end
        end
        count_next = kept;
    end

    logic         done_reg;
    logic [1:0]   count_reg;
    logic [W-1:0] slot_x_reg [NE];
    logic [W-1:0] slot_y_reg [NE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_vld_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        slot_x_reg <= slot_x_next;
        slot_y_reg <= slot_y_next;
    end

    assign done        = done_reg;
    assign point_count = count_reg;
    assign first_x     = slot_x_reg[0];
    assign first_y     = slot_y_reg[0];
    assign second_x    = slot_x_reg[1];
    assign second_y    = slot_y_reg[1];
    assign third_x     = slot_x_reg[2];
    assign third_y     = slot_y_reg[2];

`ifndef NO_ASSERTIONS
    // every result traces back to a matching start transfer
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching start");

    // unused slots are zero
    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && point_count < 2'd2) |-> (second_x == '0 && second_y == '0))
        else $error("second slot not cleared");

    a_third_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && point_count != 2'd3) |-> (third_x == '0 && third_y == '0))
        else $error("third slot not cleared");
`endif

endmodule
